>>> rtl/core/sts_pkg.sv
package sts_pkg;

    localparam int LINE_COUNT_BITS = 24;
    localparam int OUT_LINE_W      = 24;
    localparam int MAX_RESULTS     = 3;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W           = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CLS_NONE     = 3'd0,
        CLS_NUMBER   = 3'd1,
        CLS_STRING   = 3'd2,
        CLS_VARIABLE = 3'd3,
        CLS_COMMAND  = 3'd4,
        CLS_SYMBOL   = 3'd5
    } cls_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNTERM  = 2'd1,
        ERR_INVALID = 2'd2
    } err_t;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_INT  = 6'b000010,
        MODE_FRAC = 6'b000100,
        MODE_VAR  = 6'b001000,
        MODE_CMD  = 6'b010000,
        MODE_STR  = 6'b100000
    } mode_t;

    typedef struct packed {
        err_t       err;
        logic [7:0] ch;
        cls_t       cls;
        kind_t      kind;
    } res_t;

    typedef struct packed {
        logic [LINE_COUNT_BITS-1:0] line;
        res_t [MAX_RESULTS-1:0]     res;
        logic [CNT_W-1:0]           cnt;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t data;
    } push_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } head_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_USCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAR)
            || (c == CH_RPAR) || (c == CH_COMMA);
    endfunction

    function automatic res_t mk_res(input kind_t k, input cls_t cl,
                                    input logic [7:0] ch, input err_t e);
        res_t r;
        r.kind = k;
        r.cls  = cl;
        r.ch   = ch;
        r.err  = e;
        return r;
    endfunction

endpackage

>>> rtl/core/sts_front.sv
module sts_front
    import sts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_take,
    input  logic [7:0] in_char,
    input  logic       in_eoi,
    output push_t      push
);

    mode_t                      mode_reg, mode_next;
    logic                       comm_reg, comm_next;
    logic [LINE_COUNT_BITS-1:0] line_reg, line_next;

    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
    localparam logic [LINE_COUNT_BITS-1:0] LINE_ONE = LINE_COUNT_BITS'(1);

    always_comb begin
        res_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]       n;
        logic                   bump;
        logic                   rescan;
        cls_t                   wcls;

        res       = '0;
        n         = '0;
        bump      = 1'b0;
        rescan    = 1'b0;
        mode_next = mode_reg;
        comm_next = comm_reg;
        wcls      = (mode_reg == MODE_VAR) ? CLS_VARIABLE : CLS_COMMAND;

        if (in_eoi) begin
            if (comm_reg) begin
                comm_next = 1'b0;
                bump      = 1'b1;
            end
            unique case (mode_reg)
                MODE_INT, MODE_FRAC: begin
                    res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_NUMBER, 8'h00, ERR_NONE);
                    n = n + 1'b1;
                end
                MODE_VAR: begin
                    res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_VARIABLE, 8'h00, ERR_NONE);
                    n = n + 1'b1;
                end
                MODE_CMD: begin
                    res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_COMMAND, 8'h00, ERR_NONE);
                    n = n + 1'b1;
                end
                MODE_STR: begin
                    res[n[IDX_W-1:0]] = mk_res(KIND_ERR, CLS_NONE, 8'h00, ERR_UNTERM);
                    n = n + 1'b1;
                end
                default: ;
            endcase
            mode_next = MODE_IDLE;
        end else if (comm_reg) begin
            if (in_char == CH_LF) begin
                bump      = 1'b1;
                comm_next = 1'b0;
            end
        end else if (in_char == CH_SEMI) begin
            comm_next = 1'b1;
        end else begin
            bump = (in_char == CH_LF);
            unique case (mode_reg)
                MODE_INT: begin
                    if (is_digit(in_char)) begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_NUMBER, in_char, ERR_NONE);
                        n = n + 1'b1;
                    end else if (in_char == CH_DOT) begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_NUMBER, in_char, ERR_NONE);
                        n = n + 1'b1;
                        mode_next = MODE_FRAC;
                    end else begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_NUMBER, 8'h00, ERR_NONE);
                        n = n + 1'b1;
                        rescan = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit(in_char)) begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_NUMBER, in_char, ERR_NONE);
                        n = n + 1'b1;
                    end else begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_NUMBER, 8'h00, ERR_NONE);
                        n = n + 1'b1;
                        rescan = 1'b1;
                    end
                end
                MODE_VAR, MODE_CMD: begin
                    if (is_letter(in_char)) begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, wcls, in_char, ERR_NONE);
                        n = n + 1'b1;
                    end else begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_END, wcls, 8'h00, ERR_NONE);
                        n = n + 1'b1;
                        rescan = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (in_char == CH_QUOTE) begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_STRING, 8'h00, ERR_NONE);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                    end else if ((in_char == CH_LF) || (in_char == CH_CR)) begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_ERR, CLS_NONE, 8'h00, ERR_UNTERM);
                        n = n + 1'b1;
                        mode_next = MODE_IDLE;
                    end else begin
                        res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_STRING, in_char, ERR_NONE);
                        n = n + 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
        end

        // character that closed a token (or any character in idle) starts afresh
        if (rescan) begin
            mode_next = MODE_IDLE;
            if (is_space(in_char)) begin
                mode_next = MODE_IDLE;
            end else if (is_symbol(in_char)) begin
                res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_SYMBOL, in_char, ERR_NONE);
                n = n + 1'b1;
                res[n[IDX_W-1:0]] = mk_res(KIND_END, CLS_SYMBOL, 8'h00, ERR_NONE);
                n = n + 1'b1;
            end else if (in_char == CH_PCT) begin
                mode_next = MODE_VAR;
            end else if (is_digit(in_char) || (in_char == CH_PLUS)
                         || (in_char == CH_MINUS)) begin
                res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_NUMBER, in_char, ERR_NONE);
                n = n + 1'b1;
                mode_next = MODE_INT;
            end else if (in_char == CH_QUOTE) begin
                mode_next = MODE_STR;
            end else if (is_letter(in_char)) begin
                res[n[IDX_W-1:0]] = mk_res(KIND_CHAR, CLS_COMMAND, in_char, ERR_NONE);
                n = n + 1'b1;
                mode_next = MODE_CMD;
            end else begin
                res[n[IDX_W-1:0]] = mk_res(KIND_ERR, CLS_NONE, 8'h00, ERR_INVALID);
                n = n + 1'b1;
            end
        end

        line_next = (bump && (line_reg != LINE_MAX)) ? line_reg + LINE_ONE : line_reg;

        push.push     = in_take && (n != '0);
        push.data.cnt  = n;
        push.data.res  = res;
        push.data.line = line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            comm_reg <= 1'b0;
            line_reg <= LINE_ONE;
        end else if (in_take) begin
            mode_reg <= mode_next;
            comm_reg <= comm_next;
            line_reg <= line_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0)
        else $error("line counter left its range");

    a_line_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> (line_reg == $past(line_reg))
                 || (line_reg == $past(line_reg) + LINE_ONE))
        else $error("line counter moved by more than one");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push |-> (push.data.cnt <= CNT_W'(MAX_RESULTS)))
        else $error("too many results for one character");
`endif

endmodule

>>> rtl/core/sts_queue.sv
module sts_queue
    import sts_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push.push && !full;
    assign do_pop     = pop && (cnt_reg != '0);
    assign head.valid = (cnt_reg != '0);
    assign head.data  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push |-> !full)
        else $error("entry pushed into full queue");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree on empty");
`endif

endmodule

>>> rtl/core/sts_back.sv
module sts_back
    import sts_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  head_t                      head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output res_t                       out_res,
    output logic [LINE_COUNT_BITS-1:0] out_line,
    output logic                       out_last
);

    logic [IDX_W-1:0]           idx_reg;
    logic                       valid_reg;
    res_t                       res_reg;
    logic [LINE_COUNT_BITS-1:0] line_reg;
    logic                       last_reg;
    logic                       adv;
    logic                       fin;

    assign adv = head.valid && (!valid_reg || out_ready);
    assign fin = (CNT_W'(idx_reg) + 1'b1) == head.data.cnt;
    assign pop = adv && fin;

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg  <= head.data.res[idx_reg];
            line_reg <= head.data.line;
            last_reg <= fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (adv) begin
                valid_reg <= 1'b1;
                idx_reg   <= fin ? '0 : idx_reg + 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_line  = line_reg;
    assign out_last  = last_reg;

`ifndef NO_ASSERTIONS
    a_idx_in_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        head.valid |-> (CNT_W'(idx_reg) < head.data.cnt))
        else $error("result index past end of entry");

    a_idx_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (idx_reg == '0))
        else $error("index not rewound after entry");

    a_no_empty_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        head.valid |-> (head.data.cnt != '0))
        else $error("entry without results in queue");
`endif

endmodule

>>> rtl/core/script_token_scanner.sv
// channel | dir | tdata (low bit up)                     | tuser     | tlast
// s_axis  | in  | char_value[7:0]                        | -         | end_of_input
// m_axis  | out | token_class[2:0] token_char[10:3]      | kind[1:0] | last
//         |     | line_number[34:11] error_code[36:35]   |           |
//         |     | zero[39:37]                            |           |
// One character is taken per cycle while the queue is not full; the front
// classifies it in that cycle. A character with n results holds the back end
// until all n have left under m_axis_tready; a 4-entry queue absorbs this.
// s_axis_tready drops only while the queue is full.
// Reset is synchronous on aresetn low: idle mode, no comment, line 1.
module script_token_scanner
    import sts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // token_class, token_char, line_number, error_code
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    push_t                      push;
    head_t                      head;
    logic                       full;
    logic                       pop;
    logic                       take;
    res_t                       out_res;
    logic [LINE_COUNT_BITS-1:0] out_line;

    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;

    sts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (take),
        .in_char (s_axis_tdata),
        .in_eoi  (s_axis_tlast),
        .push    (push)
    );

    sts_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (full),
        .head    (head)
    );

    sts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_line  (out_line),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_res.err, OUT_LINE_W'(out_line), out_res.ch,
                           out_res.cls};
    assign m_axis_tuser = out_res.kind;

endmodule
